@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check on clk, disabled while rst_n is low
`define SUD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check on an explicit clock and active-low reset
`define SUD_ASSERT_CR(label, clock, resetn, prop, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) prop) else $error(msg);
`else
`define SUD_ASSERT(label, prop, msg)
`define SUD_ASSERT_CR(label, clock, resetn, prop, msg)
`endif
`endif

@@ design/sud_pkg.sv @@
// ----------------------------------------------------------------------------
// sud_pkg
// Shared constants and types of the signed/unsigned 64-bit divider.
// ----------------------------------------------------------------------------
package sud_pkg;

    localparam int DATA_WIDTH = 64;
    localparam int CNT_W      = $clog2(DATA_WIDTH);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_WIDTH - 1);

    localparam logic CMD_UNSIGNED = 1'b0;
    localparam logic CMD_SIGNED   = 1'b1;

    // Sequencer states of the shared subtract unit
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } sud_state_t;

    // Sign and special-case marks carried alongside an item
    typedef struct packed {
        logic neg_q;
        logic neg_r;
        logic dz;
    } sud_side_t;

endpackage

@@ design/signed_unsigned_divider_64_core.sv @@
// ----------------------------------------------------------------------------
// signed_unsigned_divider_64_core
// 64-bit signed/unsigned divider with quotient, remainder and zero flag.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: s_tuser selects unsigned (0) or signed (1) division,
//   s_tdata carries dividend and divisor. Output stream m_*: m_tdata carries
//   quotient and remainder, m_tuser flags a zero divisor.
//   Signed results truncate toward zero; the remainder follows the dividend.
//   A zero divisor gives an all-ones quotient before sign fix and remainder 0.
//   An accepted item runs the restoring iterations on the shared subtractor
//   and then moves into the output register, which drives m_tvalid; a zero
//   divisor skips the iterations and goes straight to that transfer.
//   The single 64-bit subtract unit takes one item at a time; s_tready is
//   low while it works.
//   The output register parts both sides: a new item can be taken while a
//   finished item still waits on m_tready. Under a long stall the next
//   result holds in the divider until the output register frees up.
//   Reset (rst_n low, asynchronous) drops any item in flight and empties the
//   output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module signed_unsigned_divider_64_core
    import sud_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [2*DATA_WIDTH-1:0]   s_tdata,   // dividend [63:0], divisor [127:64]
    input  logic                      s_tuser,   // command [0]
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [2*DATA_WIDTH-1:0]   m_tdata,   // quotient [63:0], remainder [127:64]
    output logic                      m_tuser    // div_by_zero [0]
);

    logic [DATA_WIDTH-1:0]  dividend;
    logic [DATA_WIDTH-1:0]  divisor;
    logic                   neg_a;
    logic                   neg_b;
    logic [DATA_WIDTH-1:0]  mag_a;
    logic [DATA_WIDTH-1:0]  mag_b;
    sud_side_t              in_side;

    logic                   done_valid;
    logic                   done_ready;
    logic [DATA_WIDTH-1:0]  done_quot;
    logic [DATA_WIDTH-1:0]  done_rem;
    sud_side_t              done_side;

    logic                   out_valid_reg, out_valid_next;
    logic [DATA_WIDTH-1:0]  quot_reg, quot_next;
    logic [DATA_WIDTH-1:0]  rem_reg, rem_next;
    logic                   dz_reg, dz_next;

    // Take magnitudes and record the sign fix-up
    always_comb
    begin
        dividend      = s_tdata[DATA_WIDTH-1:0];
        divisor       = s_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
        neg_a         = (s_tuser == CMD_SIGNED) && dividend[DATA_WIDTH-1];
        neg_b         = (s_tuser == CMD_SIGNED) && divisor[DATA_WIDTH-1];
        mag_a         = neg_a ? (~dividend + DATA_WIDTH'(1)) : dividend;
        mag_b         = neg_b ? (~divisor + DATA_WIDTH'(1)) : divisor;
        in_side.neg_q = neg_a ^ neg_b;
        in_side.neg_r = neg_a;
        in_side.dz    = (divisor == '0);
    end

    sud_div_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .start_valid (s_tvalid),
        .start_ready (s_tready),
        .start_num   (mag_a),
        .start_den   (mag_b),
        .start_side  (in_side),
        .done_valid  (done_valid),
        .done_ready  (done_ready),
        .done_quot   (done_quot),
        .done_rem    (done_rem),
        .done_side   (done_side)
    );

    // Advance a finished item when the output register is free or draining
    assign done_ready = !out_valid_reg || m_tready;

    // Apply signs and load the output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        quot_next      = quot_reg;
        rem_next       = rem_reg;
        dz_next        = dz_reg;
        if (done_valid && done_ready)
        begin
            out_valid_next = 1'b1;
            quot_next      = done_side.neg_q ? (~done_quot + DATA_WIDTH'(1)) : done_quot;
            rem_next       = done_side.neg_r ? (~done_rem + DATA_WIDTH'(1)) : done_rem;
            dz_next        = done_side.dz;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dz_reg   <= dz_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {rem_reg, quot_reg};
    assign m_tuser  = dz_reg;

    `SUD_ASSERT_CR(a_busy_after_accept, clk, rst_n, (s_tvalid && s_tready) |=> !s_tready, "new item taken while divider busy")
    `SUD_ASSERT(a_transfer_shows, (done_valid && done_ready) |=> m_tvalid, "finished item not presented")
    `SUD_ASSERT(a_dz_rem_zero, (m_tvalid && m_tuser) |-> (m_tdata[2*DATA_WIDTH-1:DATA_WIDTH] == '0), "divide by zero with nonzero remainder")

endmodule

@@ design/sud_div_core.sv @@
// ----------------------------------------------------------------------------
// sud_div_core
// Restoring divider on magnitudes: one shared subtractor, one quotient bit
// per cycle under a small sequencer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sud_div_core
    import sud_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start_valid,
    output logic                  start_ready,
    input  logic [DATA_WIDTH-1:0] start_num,
    input  logic [DATA_WIDTH-1:0] start_den,
    input  sud_side_t             start_side,
    output logic                  done_valid,
    input  logic                  done_ready,
    output logic [DATA_WIDTH-1:0] done_quot,
    output logic [DATA_WIDTH-1:0] done_rem,
    output sud_side_t             done_side
);

    sud_state_t             state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [DATA_WIDTH-1:0]  n_reg, n_next;
    logic [DATA_WIDTH-1:0]  d_reg, d_next;
    logic [DATA_WIDTH-1:0]  r_reg, r_next;
    logic [DATA_WIDTH-1:0]  q_reg, q_next;
    sud_side_t              side_reg, side_next;

    logic                   carry;
    logic [DATA_WIDTH-1:0]  shifted;
    logic [DATA_WIDTH:0]    diff;
    logic                   take;

    // Shared step: shift in the next dividend bit, trial subtract
    always_comb
    begin
        carry   = r_reg[DATA_WIDTH-1];
        shifted = {r_reg[DATA_WIDTH-2:0], n_reg[DATA_WIDTH-1]};
        diff    = {1'b0, shifted} - {1'b0, d_reg};
        take    = carry | ~diff[DATA_WIDTH];
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start_valid)
                begin
                    state_next = start_side.dz ? ST_DONE : ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (done_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Handshake outputs
    always_comb
    begin
        start_ready = (state_reg == ST_IDLE);
        done_valid  = (state_reg == ST_DONE);
    end

    // Datapath next values
    always_comb
    begin
        cnt_next  = cnt_reg;
        n_next    = n_reg;
        d_next    = d_reg;
        r_next    = r_reg;
        q_next    = q_reg;
        side_next = side_reg;
        if (start_valid && start_ready)
        begin
            cnt_next  = CNT_LAST;
            n_next    = start_num;
            d_next    = start_den;
            side_next = start_side;
            r_next    = '0;
            // Divide by zero: all-ones quotient, zero remainder
            q_next    = start_side.dz ? '1 : '0;
        end
        else if (state_reg == ST_RUN)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
            n_next   = {n_reg[DATA_WIDTH-2:0], 1'b0};
            r_next   = take ? diff[DATA_WIDTH-1:0] : shifted;
            q_next   = {q_reg[DATA_WIDTH-2:0], take};
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        d_reg    <= d_next;
        r_reg    <= r_next;
        q_reg    <= q_next;
        side_reg <= side_next;
    end

    assign done_quot = q_reg;
    assign done_rem  = r_reg;
    assign done_side = side_reg;

    `SUD_ASSERT(a_run_ends, (state_reg == ST_RUN && cnt_reg == '0) |=> (state_reg == ST_DONE), "last iteration did not finish")
    `SUD_ASSERT(a_start_run, (start_valid && start_ready && !start_side.dz) |=> (state_reg == ST_RUN && cnt_reg == CNT_LAST), "start did not load the iteration count")
    `SUD_ASSERT(a_dz_skip, (start_valid && start_ready && start_side.dz) |=> (state_reg == ST_DONE && r_reg == '0), "divide by zero did not skip to done")
    `SUD_ASSERT(a_done_hold, (state_reg == ST_DONE && !done_ready) |=> (state_reg == ST_DONE && $stable(q_reg)), "finished quotient lost before transfer")

endmodule

@@ dv/signed_unsigned_divider_64_core_test.sv @@
// ----------------------------------------------------------------------------
// signed_unsigned_divider_64_core_test
// Self-checking bench for the 64-bit signed/unsigned divider. A directed set
// covers the operand extremes, division by zero and the most negative value
// divided by minus one. Random operands of mixed magnitude then follow, with
// random gaps on the sender and random stalls on the receiver. Each result is
// compared field by field with a quotient and remainder worked out in the
// bench from the operand magnitudes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module signed_unsigned_divider_64_core_test;
    import sud_pkg::*;

    localparam int RANDOM_ITEMS = 1580;
    localparam int QUIET_LIMIT  = 5000;
    localparam int SETTLE_TIME  = 150;
    localparam int IDLE_PCT     = 27;

    localparam logic [DATA_WIDTH-1:0] ALL_ONES = '1;
    localparam logic [DATA_WIDTH-1:0] MOST_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic [DATA_WIDTH-1:0] MOST_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] ONE      = DATA_WIDTH'(1);

    // One quotient/remainder pair with its zero-divisor flag
    typedef struct {
        logic [DATA_WIDTH-1:0] quotient;
        logic [DATA_WIDTH-1:0] remainder;
        logic                  div_by_zero;
    } quot_rem_t;

    // Tracks the results still owed by the divider, oldest first
    class div_scoreboard;
        quot_rem_t quot_rem_due[$];
        int        errors;

        function new();
            errors = 0;
        endfunction

        // Truncating division on magnitudes, then sign fix-up
        function quot_rem_t divide(logic cmd, logic [DATA_WIDTH-1:0] num,
                                   logic [DATA_WIDTH-1:0] den);
            logic [DATA_WIDTH-1:0] mag_num;
            logic [DATA_WIDTH-1:0] mag_den;
            logic [DATA_WIDTH-1:0] quo;
            logic [DATA_WIDTH-1:0] rem;
            logic                  flip_quo;
            logic                  flip_rem;
            quot_rem_t             res;
            mag_num  = num;
            mag_den  = den;
            flip_quo = 1'b0;
            flip_rem = 1'b0;
            if (cmd == CMD_SIGNED)
            begin
                if (den[DATA_WIDTH-1])
                begin
                    mag_den  = -den;
                    flip_quo = 1'b1;
                end
                if (num[DATA_WIDTH-1])
                begin
                    mag_num  = -num;
                    flip_quo = !flip_quo;
                    flip_rem = 1'b1;
                end
            end
            // Zero divisor: all ones before the sign fix, remainder cleared
            if (den == '0)
            begin
                quo = ALL_ONES;
                rem = '0;
            end
            else
            begin
                quo = mag_num / mag_den;
                rem = mag_num % mag_den;
            end
            res.quotient    = flip_quo ? -quo : quo;
            res.remainder   = flip_rem ? -rem : rem;
            res.div_by_zero = (den == '0);
            return res;
        endfunction

        function void note_input(logic cmd, logic [DATA_WIDTH-1:0] num,
                                 logic [DATA_WIDTH-1:0] den);
            quot_rem_due.push_back(divide(cmd, num, den));
        endfunction

        function void check_result(logic [DATA_WIDTH-1:0] quo,
                                   logic [DATA_WIDTH-1:0] rem, logic dz);
            quot_rem_t want;
            if (quot_rem_due.size() == 0)
            begin
                $error("result with nothing pending: quotient %h remainder %h flag %b",
                       quo, rem, dz);
                errors++;
                return;
            end
            want = quot_rem_due.pop_front();
            if (quo !== want.quotient)
            begin
                $error("quotient: expected %h, actual %h", want.quotient, quo);
                errors++;
            end
            if (rem !== want.remainder)
            begin
                $error("remainder: expected %h, actual %h", want.remainder, rem);
                errors++;
            end
            if (dz !== want.div_by_zero)
            begin
                $error("div_by_zero: expected %b, actual %b", want.div_by_zero, dz);
                errors++;
            end
        endfunction

        function int outstanding();
            return quot_rem_due.size();
        endfunction
    endclass

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [2*DATA_WIDTH-1:0] s_tdata;   // dividend [63:0], divisor [127:64]
    logic                    s_tuser;   // command [0]
    logic                    m_tvalid;
    logic                    m_tready;
    logic [2*DATA_WIDTH-1:0] m_tdata;   // quotient [63:0], remainder [127:64]
    logic                    m_tuser;   // div_by_zero [0]

    div_scoreboard book = new();
    bit            calm = 1'b0;
    int            quiet_cycles = 0;

    signed_unsigned_divider_64_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Abort when no item moves on either side for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic bit take_break();
        return !calm && ($urandom_range(99) < IDLE_PCT);
    endfunction

    // Offer one item, idling at random first; leave tvalid high after accept
    task automatic send_item(input logic cmd, input logic [DATA_WIDTH-1:0] num,
                             input logic [DATA_WIDTH-1:0] den);
        while (take_break())
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {den, num};
        do
            @(posedge clk);
        while (!s_tready);
        book.note_input(cmd, num, den);
    endtask

    // Hold the sender until every owed result has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (book.outstanding() != 0);
    endtask

    // Take results, stalling at random
    task automatic drain_results();
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                book.check_result(m_tdata[DATA_WIDTH-1:0],
                                  m_tdata[2*DATA_WIDTH-1:DATA_WIDTH], m_tuser);
            m_tready <= !take_break();
        end
    endtask

    // Operands of mixed size so quotients of every length show up
    function automatic logic [DATA_WIDTH-1:0] pick_operand();
        logic [DATA_WIDTH-1:0] val;
        val = {$urandom, $urandom};
        case ($urandom_range(6))
            0: val = DATA_WIDTH'($urandom_range(15));
            1: val = -DATA_WIDTH'($urandom_range(15));
            2: val = val >> $urandom_range(DATA_WIDTH - 1);
            3: val = -(val >> $urandom_range(DATA_WIDTH - 1));
            4:
            begin
                case ($urandom_range(4))
                    0: val = '0;
                    1: val = ONE;
                    2: val = ALL_ONES;
                    3: val = MOST_NEG;
                    default: val = MOST_POS;
                endcase
            end
            default: ;
        endcase
        return val;
    endfunction

    task automatic run_directed();
        // Unsigned corners
        send_item(CMD_UNSIGNED, '0, '0);
        send_item(CMD_UNSIGNED, ALL_ONES, '0);
        send_item(CMD_UNSIGNED, ALL_ONES, ONE);
        send_item(CMD_UNSIGNED, ALL_ONES, ALL_ONES);
        send_item(CMD_UNSIGNED, '0, ALL_ONES);
        send_item(CMD_UNSIGNED, ONE, ALL_ONES);
        send_item(CMD_UNSIGNED, DATA_WIDTH'(100), DATA_WIDTH'(7));
        send_item(CMD_UNSIGNED, MOST_NEG, DATA_WIDTH'(3));
        send_item(CMD_UNSIGNED, ALL_ONES, MOST_NEG);
        // Signed corners, most negative by minus one among them
        send_item(CMD_SIGNED, MOST_NEG, ALL_ONES);
        send_item(CMD_SIGNED, MOST_NEG, ONE);
        send_item(CMD_SIGNED, MOST_NEG, MOST_NEG);
        send_item(CMD_SIGNED, ALL_ONES, MOST_NEG);
        send_item(CMD_SIGNED, MOST_POS, ALL_ONES);
        send_item(CMD_SIGNED, MOST_POS, MOST_NEG);
        send_item(CMD_SIGNED, ALL_ONES, ALL_ONES);
        send_item(CMD_SIGNED, -DATA_WIDTH'(7), DATA_WIDTH'(2));
        send_item(CMD_SIGNED, DATA_WIDTH'(7), -DATA_WIDTH'(2));
        send_item(CMD_SIGNED, -DATA_WIDTH'(7), -DATA_WIDTH'(2));
        send_item(CMD_SIGNED, DATA_WIDTH'(7), DATA_WIDTH'(2));
        send_item(CMD_SIGNED, '0, ALL_ONES);
        // Signed division by zero, both dividend signs
        send_item(CMD_SIGNED, -DATA_WIDTH'(5), '0);
        send_item(CMD_SIGNED, DATA_WIDTH'(5), '0);
        send_item(CMD_SIGNED, MOST_NEG, '0);
    endtask

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = CMD_UNSIGNED;
        m_tready = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        fork
            drain_results();
        join_none
        @(posedge clk);

        run_directed();
        wait_drained();

        for (int idx = 0; idx < RANDOM_ITEMS; idx++)
        begin
            // Run a long stretch with no idling on either side
            calm = (idx >= 400) && (idx < 700);
            send_item(logic'($urandom_range(1)), pick_operand(), pick_operand());
            if (idx % 500 == 499)
                wait_drained();
        end

        // Let the last results and any straggler through
        wait_drained();
        repeat (SETTLE_TIME) @(posedge clk);
        if (book.errors == 0 && book.outstanding() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
